// ===== rtl/lbct_pkg.sv =====
// Shared types and constants of the LRU block cache tag engine.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package lbct_pkg;

   // Field widths of the request and response beats
   localparam int OPCODE_W    = 2;
   localparam int BLOCK_W     = 16;
   localparam int KIND_W      = 2;
   localparam int SLOT_FLD_W  = 4;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 24;

   // Request opcodes
   typedef enum logic [OPCODE_W-1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_SYNC   = 2'd2,
      OP_UNUSED = 2'd3
   } opcode_type;

   // Response event kinds
   typedef enum logic [KIND_W-1:0] {
      EV_HIT      = 2'd0,
      EV_MISS     = 2'd1,
      EV_SYNC_WB  = 2'd2,
      EV_SYNC_END = 2'd3
   } event_kind_type;

   // Control handed from the sequencer to every cell of the recency chain
   typedef struct packed {
      logic capture;   // latch the tag compare against the lookup key
      logic shift;     // cells at or above the selected rank take their upper neighbor
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/lbct_cell.sv =====
// One cell of the recency chain: holds the slot at one LRU rank.
// Depends on lbct_pkg; instantiated SLOTS times by lru_block_cache_tags_top.
`default_nettype none

module lbct_cell
   import lbct_pkg::*;
#(
   parameter int SLOT_W = 4,
   parameter int INDEX  = 0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cell_ctrl_type       ctrl,
   input  wire logic [BLOCK_W-1:0]  key,
   input  wire logic                sel_in,
   input  wire logic [SLOT_W-1:0]   upper_id,
   input  wire logic [BLOCK_W-1:0]  upper_tag,
   input  wire logic                upper_valid,
   input  wire logic                upper_dirty,
   output logic [SLOT_W-1:0]        id,
   output logic [BLOCK_W-1:0]       tag,
   output logic                     valid,
   output logic                     dirty,
   output logic                     match,
   output logic                     sel_out
);

   logic [SLOT_W-1:0]  id_ff;
   logic [BLOCK_W-1:0] tag_ff;
   logic               valid_ff;
   logic               dirty_ff;
   logic               match_ff;
   logic               match_in;
   logic               take;

   // Select from the hit rank upward; the flag ripples to the next cell
   assign sel_out  = sel_in | match_ff;
   assign take     = ctrl.shift & sel_out;
   assign match_in = valid_ff && (tag_ff == key);

   // Hold slot identity and flags; reset puts slot INDEX at rank INDEX
   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff    <= SLOT_W'(INDEX);
         valid_ff <= 1'b0;
         dirty_ff <= 1'b0;
      end else if (take) begin
         id_ff    <= upper_id;
         valid_ff <= upper_valid;
         dirty_ff <= upper_dirty;
      end
   end

   // Tag and compare result carry no reset
   always_ff @(posedge clock) begin
      if (take) begin
         tag_ff <= upper_tag;
      end
      if (ctrl.capture) begin
         match_ff <= match_in;
      end
   end

   assign id    = id_ff;
   assign tag   = tag_ff;
   assign valid = valid_ff;
   assign dirty = dirty_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

// ===== rtl/lru_block_cache_tags_top.sv =====
// Top level of the LRU block cache tag engine: sequencer, recency chain, response register.
// Depends on lbct_pkg and lbct_cell.
//
// Usage:
//   req_*  carries one request beat: opcode (read, write, sync) and a block number.
//   rsp_*  carries result beats: event kind, slot, writeback flag, evicted block;
//          rsp_tlast marks the final beat caused by a request.
//   A read or write gives one beat. A sync gives one beat per dirty slot, least
//   recent first, then a done beat. The unused opcode is taken and dropped.
// Sequence:
//   Read/write: accepted, then tag compare (ST_MATCH), hit select (ST_PICK) and
//   chain update (ST_UPDATE); the result is registered in the response register
//   as the chain updates, and both wait while the receiver stalls. The next
//   request is taken once the sequencer is back in idle.
//   Sync: the chain rotates once through all SLOTS ranks, holding while a
//   writeback waits on a stalled receiver, then the done beat is given and the
//   next request is taken. The unused opcode leaves the sequencer idle.
//   Requests are handled one at a time by the single shared compare/select path over the chain.
// Reset: all slots empty and clean, slot i at recency rank i. Tags need no clear.
// Stall: a result waits in the response register; the chain holds until it is taken.
`default_nettype none

module lru_block_cache_tags_top
   import lbct_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // opcode[1:0], block_number[17:2]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // event_kind[1:0], slot[5:2],
                                                   // evict_writeback[6], evicted_block[22:7]
   output logic                       rsp_tlast
);

   localparam int SW = $clog2(SLOTS);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MATCH  = 6'b000010,
      ST_PICK   = 6'b000100,
      ST_UPDATE = 6'b001000,
      ST_SYNC   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   opcode_type         op_ff;
   logic [BLOCK_W-1:0] key_ff;
   logic [SW-1:0]      cnt_ff, cnt_in;
   logic               hit_ff;
   logic [SW-1:0]      hit_id_ff;
   logic               hit_dirty_ff;

   // Chain wiring
   cell_ctrl_type      ctrl;
   logic [SW-1:0]      c_id    [SLOTS];
   logic [BLOCK_W-1:0] c_tag   [SLOTS];
   logic               c_valid [SLOTS];
   logic               c_dirty [SLOTS];
   logic [SLOTS-1:0]   c_match;
   logic [SLOTS:0]     c_sel;
   logic               sel_base;
   logic [SW-1:0]      top_id;
   logic [BLOCK_W-1:0] top_tag;
   logic               top_valid;
   logic               top_dirty;

   // Response register
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic               rsp_last_ff;
   logic               out_free;
   logic               emit;
   event_kind_type     emit_kind;
   logic [SW-1:0]      emit_slot;
   logic               emit_wb;
   logic [BLOCK_W-1:0] emit_blk;
   logic               emit_last;

   // Hit select
   logic [SW-1:0]      pick_id;
   logic               pick_dirty;

   logic               req_beat;
   logic               sync_need;
   logic               sync_step;
   logic               is_write;
   logic               miss_wb;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_write   = (op_ff == OP_WRITE);
   assign miss_wb    = c_valid[0] && c_dirty[0];
   assign sync_need  = c_valid[0] && c_dirty[0];
   assign sync_step  = (state_ff == ST_SYNC) && (!sync_need || out_free);
   assign c_sel[0]   = sel_base;

   // Build the recency chain, rank 0 (least recent) at the bottom
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic [SW-1:0]      up_id;
      logic [BLOCK_W-1:0] up_tag;
      logic               up_valid;
      logic               up_dirty;
      if (i == SLOTS - 1) begin : g_top
         assign up_id    = top_id;
         assign up_tag   = top_tag;
         assign up_valid = top_valid;
         assign up_dirty = top_dirty;
      end else begin : g_mid
         assign up_id    = c_id[i+1];
         assign up_tag   = c_tag[i+1];
         assign up_valid = c_valid[i+1];
         assign up_dirty = c_dirty[i+1];
      end
      lbct_cell #(
         .SLOT_W (SW),
         .INDEX  (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .key         (key_ff),
         .sel_in      (c_sel[i]),
         .upper_id    (up_id),
         .upper_tag   (up_tag),
         .upper_valid (up_valid),
         .upper_dirty (up_dirty),
         .id          (c_id[i]),
         .tag         (c_tag[i]),
         .valid       (c_valid[i]),
         .dirty       (c_dirty[i]),
         .match       (c_match[i]),
         .sel_out     (c_sel[i+1])
      );
   end

   // Gather the single matching slot; tags of valid slots are unique
   always_comb begin
      pick_id    = '0;
      pick_dirty = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         pick_id    = pick_id | (c_id[i] & {SW{c_match[i]}});
         pick_dirty = pick_dirty | (c_dirty[i] & c_match[i]);
      end
   end

   // Sequencer: chain control, entry entering at the top, response beat
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ctrl.capture = 1'b0;
      ctrl.shift   = 1'b0;
      sel_base     = 1'b0;
      top_id       = c_id[0];
      top_tag      = c_tag[0];
      top_valid    = c_valid[0];
      top_dirty    = 1'b0;
      emit         = 1'b0;
      emit_kind    = EV_HIT;
      emit_slot    = '0;
      emit_wb      = 1'b0;
      emit_blk     = '0;
      emit_last    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               unique case (opcode_type'(req_tdata[OPCODE_W-1:0]))
                  OP_READ, OP_WRITE: state_in = ST_MATCH;
                  OP_SYNC: begin
                     state_in = ST_SYNC;
                     cnt_in   = '0;
                  end
                  OP_UNUSED: state_in = ST_IDLE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_MATCH: begin
            ctrl.capture = 1'b1;
            state_in     = ST_PICK;
         end
         ST_PICK: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // Move the hit slot, or the victim at rank 0, to the most recent rank
            sel_base  = !hit_ff;
            top_tag   = key_ff;
            top_valid = 1'b1;
            if (hit_ff) begin
               top_id    = hit_id_ff;
               top_dirty = hit_dirty_ff | is_write;
               emit_kind = EV_HIT;
               emit_slot = hit_id_ff;
            end else begin
               top_id    = c_id[0];
               top_dirty = is_write;
               emit_kind = EV_MISS;
               emit_slot = c_id[0];
               emit_wb   = miss_wb;
               emit_blk  = miss_wb ? c_tag[0] : '0;
            end
            if (out_free) begin
               emit       = 1'b1;
               ctrl.shift = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_SYNC: begin
            // Rotate the chain once through; write back dirty slots at rank 0
            sel_base  = 1'b1;
            emit_kind = EV_SYNC_WB;
            emit_slot = c_id[0];
            emit_blk  = c_tag[0];
            emit_last = 1'b0;
            if (sync_step) begin
               ctrl.shift = 1'b1;
               emit       = sync_need;
               if (cnt_ff == SW'(SLOTS - 1)) begin
                  state_in = ST_DONE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            emit_kind = EV_SYNC_END;
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: request, hit select, response beat
   always_ff @(posedge clock) begin
      if (req_beat) begin
         op_ff  <= opcode_type'(req_tdata[OPCODE_W-1:0]);
         key_ff <= req_tdata[OPCODE_W +: BLOCK_W];
      end
      if (state_ff == ST_PICK) begin
         hit_ff       <= |c_match;
         hit_id_ff    <= pick_id;
         hit_dirty_ff <= pick_dirty;
      end
      if (emit) begin
         rsp_data_ff <= {1'b0, emit_blk, emit_wb, SLOT_FLD_W'(emit_slot), emit_kind};
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // At most one valid slot can hold the looked-up block
   a_unique_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> $onehot0(c_match))
      else $error("more than one slot matched the lookup key");

   // Only sync writebacks leave a request unfinished
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |->
         (rsp_data_ff[KIND_W-1:0] == EV_SYNC_WB))
      else $error("non-final response beat that is not a sync writeback");

   // A dirty slot waiting on a stalled receiver holds the rotation
   a_sync_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SYNC && sync_need && !out_free) |=>
         ($stable(cnt_ff) && state_ff == ST_SYNC))
      else $error("sync rotation advanced while a writeback was blocked");

   // No request is taken while a lookup or sync is in progress
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_tdata[OPCODE_W-1:0] != OP_UNUSED) |=> !req_tready)
      else $error("request taken while busy");

endmodule

`default_nettype wire
